// ----- sv/gws_pkg.sv -----
// Shared types, constants and the coefficient generator for the Gaussian window smoother.
`default_nettype none

package gws_pkg;

	localparam int NCH          = 6;
	localparam int DATA_W       = 32;
	localparam int ACC_W        = 64;
	localparam int SERIES_TERMS = 24;

	localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

	// per-lane strobes issued by the sequencer
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic first;
	} lane_ctrl_t;

	// unsigned quotient by restoring long division; den must be non-zero
	function automatic logic [63:0] gws_udiv(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] part;
		logic [63:0] quo;
		part = '0;
		quo  = '0;
		for (int b = 63; b >= 0; b--) begin
			part = {part[63:0], num[b]};
			if (part >= {1'b0, den}) begin
				part   = part - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Q32 value of e^-(rem/den) by a truncated Taylor series
	function automatic logic [63:0] gws_exp_neg(input logic [63:0] rem, input logic [63:0] den);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		term = 64'd1 << 32;
		pos  = 64'd1 << 32;
		neg  = 64'd0;
		for (int k = 1; k <= SERIES_TERMS; k++) begin
			term = gws_udiv(term * rem, den * 64'(k));
			if (k % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

	// Q32 Gaussian weight at distance d from the centre tap
	function automatic logic [63:0] gws_gauss(input int d, input int sigma);
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] n;
		logic [63:0] e1;
		logic [63:0] g;
		logic [63:0] j;
		num = 64'(d) * 64'(d);
		den = 64'd2 * 64'(sigma) * 64'(sigma);
		if (den == 64'd0) begin
			den = 64'd1;
		end
		n  = gws_udiv(num, den);
		g  = gws_exp_neg(num - n * den, den);
		e1 = gws_exp_neg(64'd1, 64'd1);
		j  = 64'd0;
		while (j < n && g != 64'd0) begin
			g = (g * e1 + (64'd1 << 31)) >> 32;
			j = j + 64'd1;
		end
		return g;
	endfunction

	// sum of the Q32 weights over the whole kernel, never zero
	function automatic logic [63:0] gws_gauss_sum(input int taps, input int sigma);
		int          klen;
		int          mid;
		int          d;
		logic [63:0] sum;
		klen = taps | 1;
		mid  = (klen - 1) >> 1;
		sum  = 64'd0;
		for (int i = 0; i < klen; i++) begin
			d   = (i < mid) ? mid - i : i - mid;
			sum = sum + gws_gauss(d, sigma);
		end
		if (sum == 64'd0) begin
			sum = 64'd1;
		end
		return sum;
	endfunction

	// normalised kernel coefficient for tap idx, cfb fraction bits, given the weight sum
	function automatic logic [63:0] gws_coef(input int taps, input int sigma, input int cfb,
			input int idx, input logic [63:0] sum);
		int          klen;
		int          mid;
		int          d;
		logic [63:0] gi;
		klen = taps | 1;
		mid  = (klen - 1) >> 1;
		d    = (idx < mid) ? mid - idx : idx - mid;
		gi   = gws_gauss(d, sigma);
		return gws_udiv((gi << cfb) + (sum >> 1), sum);
	endfunction

endpackage

`default_nettype wire

// ----- sv/gws_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module gws_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 101,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/gws_lane.sv -----
// One channel lane: sample window RAM and a pipelined multiply-accumulate.
`default_nettype none

module gws_lane import gws_pkg::*; #(
	parameter int DEPTH  = 101,
	parameter int ADDR_W = 7,
	parameter int COEF_W = 25
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire lane_ctrl_t              ctrl,
	input  wire logic [ADDR_W-1:0]       wr_addr,
	input  wire logic [ADDR_W-1:0]       rd_addr,
	input  wire logic [DATA_W-1:0]       wr_data,
	input  wire logic [COEF_W-1:0]       coef,
	output logic signed [ACC_W-1:0]      acc
);

	localparam int PROD_W = DATA_W + COEF_W + 1;

	logic [DATA_W-1:0]        data_s1;
	logic [COEF_W-1:0]        coef_s1;
	logic                     v_s1;
	logic                     first_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2;
	logic                     first_s2;
	logic signed [ACC_W-1:0]  acc_q;

	gws_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_win (
		.clk    (clk),
		.wr_en  (ctrl.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (ctrl.rd_en),
		.rd_addr(rd_addr),
		.rd_data(data_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
		end else begin
			v_s1     <= ctrl.rd_en;
			first_s1 <= ctrl.first;
			v_s2     <= v_s1;
			first_s2 <= first_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			coef_s1 <= coef;
		end
		if (v_s1) begin
			prod_s2 <= $signed(data_s1) * $signed({1'b0, coef_s1});
		end
		// restart the sum on the first tap of a run
		if (v_s2) begin
			if (first_s2) begin
				acc_q <= ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

// ----- sv/gws_merge.sv -----
// Merging stage: rounds and saturates the lane sums into the output register.
`default_nettype none

module gws_merge import gws_pkg::*; #(
	parameter int COEF_FRAC_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  load,
	input  wire logic signed [ACC_W-1:0] acc [NCH],
	output logic                       free,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [NCH*DATA_W-1:0]      m_tdata
);

	localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

	logic signed [ACC_W-1:0]  rnd [NCH];
	logic signed [ACC_W-1:0]  shr [NCH];
	logic [NCH*DATA_W-1:0]    res;
	logic                     valid_q;
	logic [NCH*DATA_W-1:0]    data_q;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			rnd[c] = acc[c] + HALF;
			shr[c] = rnd[c] >>> COEF_FRAC_BITS;
			if (shr[c] > SAT_MAX) begin
				res[c*DATA_W +: DATA_W] = SAT_MAX[DATA_W-1:0];
			end else if (shr[c] < SAT_MIN) begin
				res[c*DATA_W +: DATA_W] = SAT_MIN[DATA_W-1:0];
			end else begin
				res[c*DATA_W +: DATA_W] = shr[c][DATA_W-1:0];
			end
		end
	end

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;

endmodule

`default_nettype wire

// ----- sv/gaussian_window_smoother.sv -----
// Gaussian window smoother: six-channel FIR smoothing of trajectory samples.
//
// Input beats arrive on s_tvalid/s_tready with the sample in s_tdata and the
// start-of-trajectory flag in s_tuser. Smoothed samples leave on
// m_tvalid/m_tready/m_tdata. A beat that does not yet fill the window of
// KLEN = TAPS|1 samples is stored and yields nothing. A beat that fills it
// starts a run over the KLEN taps, one tap per cycle in each of six channel
// lanes, reading the window RAMs oldest first; each product passes the lane
// read, product and accumulator registers, and the sum lands in the output
// register. No new beat is taken until the run has handed its result over,
// so one window is worked on at a time. The tap loop over each lane's window
// RAM read port limits how fast full-window samples can be smoothed.
// The output register holds a result until taken; the next beat is accepted
// meanwhile, and its result waits in the lanes, with s_tready low, while
// m_tready is low. Reset empties the window count and clears the output
// valid; window RAM contents are not cleared. The kernel ROM is built at
// elaboration.
`default_nettype none

module gaussian_window_smoother import gws_pkg::*; #(
	parameter int TAPS           = 101,
	parameter int SIGMA          = 15,
	parameter int COEF_FRAC_BITS = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z from the lowest bit up
	input  wire logic [NCH*DATA_W-1:0] s_tdata,
	// start_new
	input  wire logic                  s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// smooth_pos_x, smooth_pos_y, smooth_pos_z, smooth_vel_x, smooth_vel_y,
	// smooth_vel_z from the lowest bit up
	output logic [NCH*DATA_W-1:0]      m_tdata
);

	localparam int KLEN   = TAPS | 1;
	localparam int ADDR_W = $clog2(KLEN);
	localparam int FILL_W = $clog2(KLEN + 1);
	localparam int COEF_W = COEF_FRAC_BITS + 1;
	localparam logic [63:0] GSUM = gws_gauss_sum(TAPS, SIGMA);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t              state_q;
	logic [FILL_W-1:0]   fill_q;
	logic [ADDR_W-1:0]   slot_q;
	logic [ADDR_W-1:0]   rd_addr_q;
	logic [ADDR_W-1:0]   tap_q;
	logic                lst_s1;
	logic                lst_s2;
	logic                lst_s3;
	logic                done_q;

	logic                accept;
	logic [ADDR_W-1:0]   base_slot;
	logic [FILL_W-1:0]   base_fill;
	logic [ADDR_W-1:0]   next_slot;
	logic [FILL_W-1:0]   next_fill;
	logic                last_tap;
	logic                out_free;
	logic                load;
	lane_ctrl_t          ctrl;
	logic [COEF_W-1:0]   coef_rom [KLEN];
	logic signed [ACC_W-1:0] acc_lane [NCH];

	for (genvar gi = 0; gi < KLEN; gi++) begin : g_rom
		localparam logic [63:0] CV = gws_coef(TAPS, SIGMA, COEF_FRAC_BITS, gi, GSUM);
		assign coef_rom[gi] = CV[COEF_W-1:0];
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign base_slot = s_tuser ? '0 : slot_q;
	assign base_fill = s_tuser ? '0 : fill_q;
	assign next_slot = (base_slot == ADDR_W'(KLEN - 1)) ? '0 : base_slot + ADDR_W'(1);
	assign next_fill = (base_fill < FILL_W'(KLEN)) ? base_fill + FILL_W'(1) : base_fill;
	assign last_tap  = (tap_q == ADDR_W'(KLEN - 1));

	assign ctrl.wr_en = accept;
	assign ctrl.rd_en = (state_q == ST_RUN);
	assign ctrl.first = (state_q == ST_RUN) && (tap_q == '0);

	// hand over once the last product has reached the accumulators
	assign load = (state_q == ST_DRAIN) && (lst_s3 || done_q) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			slot_q    <= '0;
			rd_addr_q <= '0;
			tap_q     <= '0;
			lst_s1    <= 1'b0;
			lst_s2    <= 1'b0;
			lst_s3    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			lst_s1 <= ctrl.rd_en && last_tap;
			lst_s2 <= lst_s1;
			lst_s3 <= lst_s2;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						slot_q <= next_slot;
						fill_q <= next_fill;
						if (next_fill == FILL_W'(KLEN)) begin
							rd_addr_q <= next_slot;
							tap_q     <= '0;
							state_q   <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					rd_addr_q <= (rd_addr_q == ADDR_W'(KLEN - 1)) ? '0
						: rd_addr_q + ADDR_W'(1);
					tap_q <= tap_q + ADDR_W'(1);
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load) begin
						done_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (lst_s3) begin
						done_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	for (genvar c = 0; c < NCH; c++) begin : g_lane
		gws_lane #(
			.DEPTH (KLEN),
			.ADDR_W(ADDR_W),
			.COEF_W(COEF_W)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.wr_addr(base_slot),
			.rd_addr(rd_addr_q),
			.wr_data(s_tdata[c*DATA_W +: DATA_W]),
			.coef   (coef_rom[tap_q]),
			.acc    (acc_lane[c])
		);
	end

	gws_merge #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.acc     (acc_lane),
		.free    (out_free),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for the six-channel Gaussian smoothing filter: stream driver, monitor, scoreboard.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gws_pkg::*;

	localparam int TAPS       = 101;
	localparam int SIGMA      = 15;
	localparam int CFB        = 24;
	localparam int KLEN       = TAPS | 1;
	localparam int SERIES_LEN = 24;
	localparam int RAND_ITEMS = 1150;
	localparam int CALM_ITEMS = 120;
	localparam int LONG_HOLD  = 2500;
	localparam int HOLD_AFTER = 150;
	localparam int MAX_PRINTS = 40;

	typedef logic [NCH-1:0][DATA_W-1:0] chan_set_t;

	// channel order 0..5: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	typedef struct packed {
		logic      start;
		chan_set_t chan;
	} sample_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [NCH*DATA_W-1:0] s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [NCH*DATA_W-1:0] m_tdata;

	gaussian_window_smoother #(
		.TAPS          (TAPS),
		.SIGMA         (SIGMA),
		.COEF_FRAC_BITS(CFB)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	longint unsigned gauss_kernel [KLEN];
	sample_t         pending [$];
	sample_t         traj_window [$];
	chan_set_t       smoothed_q [$];

	int   errors      = 0;
	int   samples_in  = 0;
	int   results_out = 0;
	int   restarts    = 0;
	logic s_took      = 1'b0;

	int   s_gap = 0, s_mode_left = 0, s_idle_pct = 0;
	int   m_gap = 0, m_mode_left = 0, m_idle_pct = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Q32 e^-(rem/den) by a 24-term alternating series, each term floored
	function automatic longint unsigned exp_q32(longint unsigned rem, longint unsigned den);
		longint unsigned term;
		longint          acc;
		term = 64'd1 << 32;
		acc  = longint'(term);
		for (int k = 1; k <= SERIES_LEN; k++) begin
			term = (term * rem) / (den * longint'(k));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		return (acc > 0) ? longint'(acc) : 64'd0;
	endfunction

	// Q32 unnormalised weight d taps away from the centre
	function automatic longint unsigned weight_q32(int d);
		longint unsigned num, den, whole, g, e1;
		num   = longint'(d) * longint'(d);
		den   = 2 * longint'(SIGMA) * longint'(SIGMA);
		whole = num / den;
		g     = exp_q32(num % den, den);
		e1    = exp_q32(1, 1);
		for (longint unsigned j = 0; j < whole && g != 0; j++) begin
			g = (g * e1 + (64'd1 << 31)) >> 32;
		end
		return g;
	endfunction

	// window update and six dot products, oldest sample first
	function automatic void take_sample(sample_t s);
		chan_set_t res;
		longint    acc;
		longint    r;
		if (s.start) begin
			traj_window.delete();
		end
		traj_window.insert(traj_window.size(), s);
		if (traj_window.size() > KLEN) begin
			void'(traj_window.pop_front());
		end
		if (traj_window.size() < KLEN) begin
			return;
		end
		for (int c = 0; c < NCH; c++) begin
			acc = 0;
			for (int i = 0; i < KLEN; i++) begin
				acc = acc + longint'($signed(traj_window[i].chan[c])) *
					longint'(gauss_kernel[i]);
			end
			r = (acc + (longint'(1) <<< (CFB - 1))) >>> CFB;
			if (r > 64'sh7FFF_FFFF) begin
				r = 64'sh7FFF_FFFF;
			end else if (r < -64'sh8000_0000) begin
				r = -64'sh8000_0000;
			end
			res[c] = r[DATA_W-1:0];
		end
		smoothed_q.insert(smoothed_q.size(), res);
	endfunction

	function automatic logic [DATA_W-1:0] draw_value(int style, logic [DATA_W-1:0] base);
		logic [DATA_W-1:0] v;
		case (style)
			0: v = $urandom;
			1: v = DATA_W'(int'($urandom_range(0, 2 << 20)) - (1 << 20));
			2: begin
				case ($urandom_range(0, 4))
					0: v = 32'h7FFF_FFFF;
					1: v = 32'h8000_0000;
					2: v = 32'h0000_0000;
					3: v = 32'hFFFF_FFFF;
					default: v = 32'h0000_0001;
				endcase
			end
			default: v = ($urandom_range(0, 19) == 0) ? DATA_W'($urandom) : base;
		endcase
		return v;
	endfunction

	function automatic void queue_sample(logic start, chan_set_t chan);
		sample_t s;
		s.start = start;
		s.chan  = chan;
		pending.insert(pending.size(), s);
	endfunction

	function automatic chan_set_t fill_all(logic [DATA_W-1:0] v);
		chan_set_t cs;
		for (int c = 0; c < NCH; c++) begin
			cs[c] = v;
		end
		return cs;
	endfunction

	// sender: present beats from the pending queue, idling in bursts
	always @(negedge clk) begin
		sample_t nxt;
		if (arst_n && (!s_tvalid || s_took)) begin
			if (s_mode_left == 0) begin
				s_mode_left = $urandom_range(200, 1500);
				case ($urandom_range(0, 2))
					0: s_idle_pct = 0;
					1: s_idle_pct = 8;
					default: s_idle_pct = 30;
				endcase
			end else begin
				s_mode_left--;
			end
			if (s_gap == 0 && pending.size() > CALM_ITEMS && $urandom_range(0, 99) < s_idle_pct) begin
				s_gap = $urandom_range(1, 18);
			end
			if (s_gap != 0) begin
				s_gap--;
				s_tvalid <= 1'b0;
			end else if (pending.size() != 0) begin
				nxt = pending.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= nxt.chan;
				s_tuser  <= nxt.start;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: random back-pressure plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && results_out >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				if (m_mode_left == 0) begin
					m_mode_left = $urandom_range(200, 1500);
					case ($urandom_range(0, 2))
						0: m_idle_pct = 0;
						1: m_idle_pct = 8;
						default: m_idle_pct = 30;
					endcase
				end else begin
					m_mode_left--;
				end
				if (m_gap == 0 && pending.size() > CALM_ITEMS &&
						$urandom_range(0, 99) < m_idle_pct) begin
					m_gap = $urandom_range(1, 18);
				end
				if (m_gap != 0) begin
					m_gap--;
					m_tready <= 1'b0;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// monitor: predict on input beats, check output beats
	always @(posedge clk) begin
		chan_set_t want;
		sample_t   got_in;
		if (arst_n) begin
			s_took <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				got_in.start = s_tuser;
				got_in.chan  = s_tdata;
				take_sample(got_in);
				samples_in++;
				if (s_tuser) begin
					restarts++;
				end
			end
			if (m_tvalid && m_tready) begin
				results_out++;
				if (smoothed_q.size() == 0) begin
					errors++;
					if (errors <= MAX_PRINTS) begin
						$display("%0t: unexpected output beat, expected none, actual %h",
							$time, m_tdata);
					end
				end else begin
					want = smoothed_q.pop_front();
					for (int c = 0; c < NCH; c++) begin
						if (m_tdata[c*DATA_W +: DATA_W] !== want[c]) begin
							errors++;
							if (errors <= MAX_PRINTS) begin
								$display("%0t: channel %0d mismatch, expected %h, actual %h",
									$time, c, want[c], m_tdata[c*DATA_W +: DATA_W]);
							end
						end
					end
				end
			end
		end
	end

	initial begin
		longint unsigned gsum;
		longint unsigned g [KLEN];
		int              mid;
		int              len;
		int              style;
		int              stop_at;
		logic [DATA_W-1:0] base;
		chan_set_t       cs;

		// build the normalised kernel
		mid  = (KLEN - 1) / 2;
		gsum = 0;
		for (int i = 0; i < KLEN; i++) begin
			g[i] = weight_q32((i < mid) ? mid - i : i - mid);
			gsum = gsum + g[i];
		end
		for (int i = 0; i < KLEN; i++) begin
			gauss_kernel[i] = ((g[i] << CFB) + gsum / 2) / gsum;
		end

		// directed: a full-scale positive window, then full-scale negative samples shifted in
		for (int i = 0; i < KLEN; i++) begin
			queue_sample(1'b0, fill_all(32'h7FFF_FFFF));
		end
		for (int i = 0; i < 10; i++) begin
			queue_sample(1'b0, fill_all(32'h8000_0000));
		end
		// restart with a trajectory too short to yield anything
		for (int i = 0; i < 30; i++) begin
			for (int c = 0; c < NCH; c++) begin
				cs[c] = draw_value(1, '0);
			end
			queue_sample(i == 0, cs);
		end
		// alternating bit patterns
		for (int i = 0; i < KLEN + 2; i++) begin
			for (int c = 0; c < NCH; c++) begin
				if (c % 2 == 0) begin
					cs[c] = (i % 2 == 0) ? 32'hAAAA_AAAA : 32'h5555_5555;
				end else begin
					cs[c] = (i % 2 == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
				end
			end
			queue_sample(i == 0, cs);
		end
		// impulse swept through every tap
		for (int i = 0; i < 2 * KLEN - 1; i++) begin
			cs = '0;
			if (i == KLEN - 1) begin
				cs[0] = 32'h7FFF_FFFF;
				cs[1] = 32'h8000_0000;
				cs[2] = 32'h0001_0000;
				cs[3] = 32'h0000_0001;
				cs[4] = 32'hFFFF_FFFF;
				cs[5] = 32'h4000_0000;
			end
			queue_sample(i == 0, cs);
		end

		// random trajectories, mostly long enough to fill the window
		stop_at = pending.size() + RAND_ITEMS;
		while (pending.size() < stop_at) begin
			len   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, KLEN - 1) :
				$urandom_range(KLEN, 260);
			style = $urandom_range(0, 3);
			base  = $urandom;
			for (int i = 0; i < len; i++) begin
				for (int c = 0; c < NCH; c++) begin
					cs[c] = draw_value(style, base);
				end
				queue_sample(i == 0 || $urandom_range(0, 199) == 0, cs);
			end
		end

		repeat (4) @(posedge clk);
		#3 arst_n = 1'b1;

		while (pending.size() != 0 || s_tvalid) begin
			@(negedge clk);
		end
		while (smoothed_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4 * (KLEN + 4)) @(negedge clk);
		if (smoothed_q.size() != 0) begin
			errors++;
			$display("%0t: %0d smoothed samples never arrived", $time, smoothed_q.size());
		end

		$display("%0d samples in, %0d smoothed samples checked, %0d trajectory restarts",
			samples_in, results_out, restarts);
		$display("covered saturation, tap-by-tap impulse sweep, short trajectories, long stall");
		if (errors == 0) begin
			$display("gaussian_window_smoother verification clean");
		end else begin
			$display("gaussian_window_smoother verification failed");
		end
		$finish;
	end

	initial begin
		#15ms;
		$display("gaussian_window_smoother verification failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/gws_pkg.sv
sv/gws_ram.sv
sv/gws_lane.sv
sv/gws_merge.sv
sv/gaussian_window_smoother.sv
tb/tb.sv
